// ===== design/dcrf_pkg.sv =====
// Types and constants shared by the DMA channel register file.
`timescale 1ns / 1ps
`default_nettype none

package dcrf_pkg;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] offset;
    logic [2:0]  access_size;
    logic [31:0] wdata;
    logic [2:0]  channel;
    logic [2:0]  done_flags;
  } req_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [7:0]  irq_lines;
    logic        start_valid;
    logic [2:0]  start_channel;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;
  localparam logic [1:0] CMD_ERROR = 2'd3;

  localparam logic [1:0] ALIAS_WR  = 2'd0;
  localparam logic [1:0] ALIAS_SET = 2'd1;
  localparam logic [1:0] ALIAS_CLR = 2'd2;
  localparam logic [1:0] ALIAS_TOG = 2'd3;

  // register map in 16-byte units
  localparam logic [8:0] REG_CTRL    = 9'h000;
  localparam logic [8:0] REG_INTR    = 9'h001;
  localparam logic [8:0] REG_DSEL    = 9'h002;
  localparam logic [8:0] REG_VER_ID  = 9'h03F;
  localparam logic [8:0] CH_BASE     = 9'h004;
  localparam int         SLOTS_PER_CH = 7;

  localparam logic [2:0] SLOT_NEXT_DESC = 3'd1;
  localparam logic [2:0] SLOT_SEMA      = 3'd4;
  localparam logic [2:0] SLOT_DEBUG1    = 3'd5;

  localparam logic [31:0] CTRL_RESET     = 32'hC000_0000;
  localparam logic [31:0] CTRL_WMASK     = 32'hC0FF_FFFF;
  localparam logic [31:0] CTRL_WMASK_EXT = 32'hC0FF_00FF;
  localparam logic [31:0] INTR_WMASK     = 32'h00FF_FFFF;
  localparam logic [31:0] DSEL_WMASK_EXT = 32'hFF00_0F00;
  localparam logic [31:0] VERSION_VALUE  = 32'h0101_0000;
  localparam logic [31:0] DEBUG1_BASE    = 32'h00A0_0000;
  localparam logic [31:0] FULL_WORD      = 32'hFFFF_FFFF;

  localparam int CTRL_SOFT_RESET_BIT = 31;
  localparam int CTRL_CLOCK_GATE_BIT = 30;

endpackage

`default_nettype wire

// ===== design/dcrf_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
`timescale 1ns / 1ps
`default_nettype none

interface dcrf_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/dcrf_ctrl.sv =====
// Controller: capture/execute sequencing and response valid.
`timescale 1ns / 1ps
`default_nettype none

module dcrf_ctrl import dcrf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dp_cmd_t dp_cmd
);

  ctrl_state_t state, state_next;
  logic        rsp_valid_next;
  logic        slot_free;

  assign slot_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready      = (state == ST_IDLE);
    dp_cmd.capture = (state == ST_IDLE) && req_valid;
    dp_cmd.execute = (state == ST_EXEC) && slot_free;
    if (dp_cmd.execute) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

endmodule

`default_nettype wire

// ===== design/dcrf_datapath.sv =====
// Datapath: register decode, read-modify-write, events and response word.
`timescale 1ns / 1ps
`default_nettype none

module dcrf_datapath import dcrf_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t dp_cmd,
  input  req_t    req_data,
  input  logic    cfg_we,
  input  logic    cfg_data,
  output rsp_t    rsp_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  req_t        item;
  rsp_t        rsp_q;
  logic        extended_variant;
  logic [31:0] control_word;
  logic [23:0] interrupt_word;
  logic [31:0] device_select;
  logic [31:0] next_descriptor [NUM_CHANNELS];
  logic [7:0]  semaphore_count [NUM_CHANNELS];

  logic [8:0]  base_k;
  logic [8:0]  ch_k;
  logic [1:0]  alias_sel;
  logic [4:0]  bit_shift;
  logic [31:0] size_mask;
  logic [31:0] lane_mask;
  logic [31:0] wdata_sh;
  logic        is_ctrl, is_intr, is_dsel, is_ver;
  logic        ch_hit;
  logic [2:0]  bus_ch;
  logic [2:0]  slot;
  logic [2:0]  sel_ch;
  logic [CH_W-1:0] idx;
  logic        ev_ok;
  logic [31:0] nd_cur;
  logic [7:0]  sem_cur;

  logic [31:0] tgt_cur, tgt_wmask, wmask, aliased, merged;
  logic [7:0]  sem_inc;
  logic [8:0]  sem_sum;

  logic [31:0] control_word_next;
  logic [23:0] interrupt_word_next;
  logic [31:0] device_select_next;
  logic        nd_we, sem_we;
  logic [31:0] nd_next;
  logic [7:0]  sem_next;
  logic        start;
  logic [31:0] rd_word;
  logic [7:0]  irq;

  // decode
  assign base_k    = item.offset[12:4];
  assign alias_sel = item.offset[3:2];
  assign bit_shift = {item.offset[1:0], 3'b000};
  assign is_ctrl   = (base_k == REG_CTRL);
  assign is_intr   = (base_k == REG_INTR);
  assign is_dsel   = (base_k == REG_DSEL);
  assign is_ver    = (base_k == REG_VER_ID);
  assign ch_k      = base_k - CH_BASE;

  always_comb begin
    ch_hit = 1'b0;
    bus_ch = '0;
    slot   = '0;
    if (base_k >= CH_BASE) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (ch_k >= 9'(SLOTS_PER_CH * i) && ch_k < 9'(SLOTS_PER_CH * (i + 1))) begin
          ch_hit = 1'b1;
          bus_ch = 3'(i);
          slot   = 3'(ch_k - 9'(SLOTS_PER_CH * i));
        end
      end
    end
  end

  assign ev_ok   = ({1'b0, item.channel} < 4'(NUM_CHANNELS));
  assign sel_ch  = (item.cmd == CMD_DONE || item.cmd == CMD_ERROR) ? item.channel : bus_ch;
  assign idx     = sel_ch[CH_W-1:0];
  assign nd_cur  = next_descriptor[idx];
  assign sem_cur = semaphore_count[idx];

  always_comb begin
    unique case (item.access_size)
      3'd0:    size_mask = 32'h0000_0000;
      3'd1:    size_mask = 32'h0000_00FF;
      3'd2:    size_mask = 32'h0000_FFFF;
      3'd3:    size_mask = 32'h00FF_FFFF;
      default: size_mask = FULL_WORD;
    endcase
  end

  assign lane_mask = size_mask << bit_shift;
  assign wdata_sh  = item.wdata << bit_shift;

  // shared read-modify-write with alias operation
  always_comb begin
    priority if (is_ctrl) begin
      tgt_cur   = control_word;
      tgt_wmask = extended_variant ? CTRL_WMASK_EXT : CTRL_WMASK;
    end else if (is_intr) begin
      tgt_cur   = {8'h00, interrupt_word};
      tgt_wmask = INTR_WMASK;
    end else if (is_dsel) begin
      tgt_cur   = device_select;
      tgt_wmask = extended_variant ? DSEL_WMASK_EXT : 32'h0000_0000;
    end else begin
      tgt_cur   = nd_cur;
      tgt_wmask = FULL_WORD;
    end
  end

  always_comb begin
    unique case (alias_sel)
      ALIAS_WR:  aliased = wdata_sh;
      ALIAS_SET: aliased = tgt_cur | wdata_sh;
      ALIAS_CLR: aliased = tgt_cur & ~wdata_sh;
      ALIAS_TOG: aliased = tgt_cur ^ wdata_sh;
      default:   aliased = wdata_sh;
    endcase
  end

  assign wmask   = tgt_wmask & lane_mask;
  assign merged  = (tgt_cur & ~wmask) | (aliased & wmask);
  assign sem_inc = (item.offset[1:0] == 2'd0) ? item.wdata[7:0] : 8'h00;
  assign sem_sum = {1'b0, sem_cur} + {1'b0, sem_inc};

  always_comb begin
    control_word_next   = control_word;
    interrupt_word_next = interrupt_word;
    device_select_next  = device_select;
    nd_we    = 1'b0;
    nd_next  = merged;
    sem_we   = 1'b0;
    sem_next = sem_cur;
    start    = 1'b0;
    rd_word  = '0;
    unique case (item.cmd)
      CMD_READ: begin
        priority if (is_ctrl) rd_word = control_word;
        else if (is_intr) rd_word = {8'h00, interrupt_word};
        else if (is_dsel) rd_word = device_select;
        else if (is_ver) rd_word = VERSION_VALUE;
        else if (ch_hit) begin
          priority if (slot == SLOT_NEXT_DESC) rd_word = nd_cur;
          else if (slot == SLOT_SEMA) rd_word = {8'h00, sem_cur, 8'h00, sem_cur};
          else if (slot == SLOT_DEBUG1)
            rd_word = DEBUG1_BASE | {7'd0, (nd_cur != '0), 20'd0, {4{sem_cur != '0}}};
          else rd_word = '0;
        end
      end
      CMD_WRITE: begin
        priority if (is_ctrl) begin
          control_word_next = merged;
          control_word_next[CTRL_CLOCK_GATE_BIT] = merged[CTRL_SOFT_RESET_BIT];
        end else if (is_intr) begin
          interrupt_word_next = merged[23:0];
        end else if (is_dsel) begin
          device_select_next = merged;
        end else if (ch_hit) begin
          if (slot == SLOT_NEXT_DESC) begin
            nd_we = 1'b1;
          end else if (slot == SLOT_SEMA) begin
            sem_we   = 1'b1;
            sem_next = sem_sum[8] ? 8'hFF : sem_sum[7:0];
            start    = (sem_inc != '0) && !control_word[CTRL_SOFT_RESET_BIT]
                       && !control_word[CTRL_CLOCK_GATE_BIT] && (nd_cur != '0);
          end
        end
      end
      CMD_DONE: begin
        if (ev_ok) begin
          if (item.done_flags[1] && sem_cur != '0) begin
            sem_we   = 1'b1;
            sem_next = sem_cur - 8'd1;
          end
          if (item.done_flags[0])
            interrupt_word_next = interrupt_word | (24'd1 << item.channel);
          start = item.done_flags[2] && (nd_cur != '0);
        end
      end
      CMD_ERROR: begin
        if (ev_ok)
          interrupt_word_next = interrupt_word | (24'd1 << (5'(item.channel) + 5'd16));
      end
      default: rd_word = '0;
    endcase
  end

  always_comb begin
    irq = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      irq[i] = (interrupt_word_next[i] && interrupt_word_next[i + 8])
               || interrupt_word_next[i + 16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extended_variant <= 1'b0;
      control_word     <= CTRL_RESET;
      interrupt_word   <= '0;
      device_select    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        next_descriptor[i] <= '0;
        semaphore_count[i] <= '0;
      end
    end else begin
      if (cfg_we) extended_variant <= cfg_data;
      if (dp_cmd.execute) begin
        control_word   <= control_word_next;
        interrupt_word <= interrupt_word_next;
        device_select  <= device_select_next;
        if (nd_we) next_descriptor[idx] <= nd_next;
        if (sem_we) semaphore_count[idx] <= sem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) item <= req_data;
    if (dp_cmd.execute) begin
      rsp_q.rdata         <= (rd_word >> bit_shift) & size_mask;
      rsp_q.irq_lines     <= irq;
      rsp_q.start_valid   <= start;
      rsp_q.start_channel <= start ? sel_ch : 3'd0;
    end
  end

  assign rsp_data = rsp_q;

endmodule

`default_nettype wire

// ===== design/dma_channel_register_file.sv =====
// Top level of the DMA channel register file.
`timescale 1ns / 1ps
`default_nettype none

// Register file of an eight-channel descriptor DMA controller. Each request
// word (bus read, bus write, command done or bus error) yields exactly one
// response word with read data, the per-channel interrupt lines and an
// optional channel start request. A word is first captured, then decoded,
// the registers updated and the response register loaded; the controller
// then takes the next word. If the previous response has not been taken,
// the update waits for the response register to free up. The variant bit
// on cfg is always accepted and may only be written while no request is in
// flight.
module dma_channel_register_file import dcrf_pkg::*; #(
  parameter int NUM_CHANNELS = 8
) (
  input logic          clk,
  input logic          rst,
  dcrf_stream_if.sink   req,
  dcrf_stream_if.source rsp,
  dcrf_stream_if.sink   cfg
);

  dp_cmd_t dp_cmd;

  assign cfg.ready = 1'b1;

  dcrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  dcrf_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .dp_cmd   (dp_cmd),
    .req_data (req.data),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.data),
    .rsp_data (rsp.data)
  );

`ifndef NO_ASSERTIONS
  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.execute |=> rsp.valid)
    else $error("response not valid after execute");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("new word taken while previous one still executing");

  a_start_chan_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.data.start_valid) |-> (rsp.data.start_channel == 3'd0))
    else $error("start channel set without start request");

  a_irq_absent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((16'(rsp.data.irq_lines) >> NUM_CHANNELS) == 16'd0))
    else $error("interrupt on absent channel");
`endif

endmodule

`default_nettype wire

// ===== test/tb_dma_channel_register_file.sv =====
// Testbench for the DMA channel register file: directed table, random accesses, shadow check.
`timescale 1ns / 1ps

module tb_dma_channel_register_file;
  import dcrf_pkg::*;

  localparam int CHANNELS = 8;
  localparam logic [2:0] SLOT_CUR_ADDR = 3'd0;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  dcrf_stream_if #(.payload_t(req_t)) req_if ();
  dcrf_stream_if #(.payload_t(rsp_t)) rsp_if ();
  dcrf_stream_if #(.payload_t(logic)) cfg_if ();

  dma_channel_register_file #(.NUM_CHANNELS(CHANNELS)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // shadow register state
  logic        sh_ext;
  logic [31:0] sh_ctrl;
  logic [23:0] sh_intr;
  logic [31:0] sh_dsel;
  logic [31:0] sh_ndesc [CHANNELS];
  logic [7:0]  sh_sema [CHANNELS];

  rsp_t     pending_rsp_q [$];
  dir_row_t directed_rows [$];
  int       mismatches;
  bit       req_burst;
  bit       rsp_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [8:0] chan_unit(input int ch, input int slot);
    return CH_BASE + 9'(ch * SLOTS_PER_CH + slot);
  endfunction

  function automatic logic [12:0] reg_offset(input logic [8:0] unit, input logic [1:0] op,
                                             input logic [1:0] lane);
    return {unit, op, lane};
  endfunction

  function automatic bit decode_channel(input logic [8:0] unit, output int ch, output int slot);
    int rel;
    ch = 0;
    slot = 0;
    if (unit < CH_BASE) return 1'b0;
    rel = int'(unit - CH_BASE);
    if (rel / SLOTS_PER_CH >= CHANNELS) return 1'b0;
    ch = rel / SLOTS_PER_CH;
    slot = rel % SLOTS_PER_CH;
    return 1'b1;
  endfunction

  function automatic logic [31:0] alias_apply(input logic [31:0] cur, input logic [31:0] v,
                                              input logic [1:0] op);
    case (op)
      ALIAS_SET: return cur | v;
      ALIAS_CLR: return cur & ~v;
      ALIAS_TOG: return cur ^ v;
      default:   return v;
    endcase
  endfunction

  // Applies one request word to the shadow state and returns its response word.
  function automatic rsp_t regfile_respond(input req_t r);
    rsp_t        o;
    logic [8:0]  unit;
    logic [4:0]  shift;
    logic [1:0]  op;
    logic [31:0] mask, lane, wsh, wmask, cur, regval;
    logic [8:0]  sum;
    int          ch, slot;
    bit          is_ch;
    o = '0;
    unit = r.offset[12:4];
    shift = {r.offset[1:0], 3'b000};
    op = r.offset[3:2];
    case (r.access_size)
      3'd0: mask = '0;
      3'd1: mask = 32'h0000_00FF;
      3'd2: mask = 32'h0000_FFFF;
      3'd3: mask = 32'h00FF_FFFF;
      default: mask = FULL_WORD;
    endcase
    lane = mask << shift;
    wsh = r.wdata << shift;
    is_ch = decode_channel(unit, ch, slot);
    case (r.cmd)
      CMD_READ: begin
        regval = '0;
        if (unit == REG_CTRL) regval = sh_ctrl;
        else if (unit == REG_INTR) regval = {8'h00, sh_intr};
        else if (unit == REG_DSEL) regval = sh_dsel;
        else if (unit == REG_VER_ID) regval = VERSION_VALUE;
        else if (is_ch && slot == SLOT_NEXT_DESC) regval = sh_ndesc[ch];
        else if (is_ch && slot == SLOT_SEMA) regval = {8'h00, sh_sema[ch], 8'h00, sh_sema[ch]};
        else if (is_ch && slot == SLOT_DEBUG1) begin
          regval = DEBUG1_BASE;
          if (sh_sema[ch] != 8'h00) regval = regval | 32'h0000_000F;
          if (sh_ndesc[ch] != 32'h0) regval = regval | 32'h0100_0000;
        end
        o.rdata = (regval >> shift) & mask;
      end
      CMD_WRITE: begin
        if (unit == REG_CTRL) begin
          wmask = (sh_ext ? CTRL_WMASK_EXT : CTRL_WMASK) & lane;
          cur = alias_apply(sh_ctrl, wsh, op);
          sh_ctrl = (sh_ctrl & ~wmask) | (cur & wmask);
          sh_ctrl[CTRL_CLOCK_GATE_BIT] = sh_ctrl[CTRL_SOFT_RESET_BIT];
        end else if (unit == REG_INTR) begin
          wmask = INTR_WMASK & lane;
          cur = alias_apply({8'h00, sh_intr}, wsh, op);
          regval = ({8'h00, sh_intr} & ~wmask) | (cur & wmask);
          sh_intr = regval[23:0];
        end else if (unit == REG_DSEL) begin
          wmask = (sh_ext ? DSEL_WMASK_EXT : 32'h0) & lane;
          cur = alias_apply(sh_dsel, wsh, op);
          sh_dsel = (sh_dsel & ~wmask) | (cur & wmask);
        end else if (is_ch && slot == SLOT_NEXT_DESC) begin
          cur = alias_apply((sh_ndesc[ch] >> shift) & mask, r.wdata, op) & mask;
          sh_ndesc[ch] = (sh_ndesc[ch] & ~lane) | (cur << shift);
        end else if (is_ch && slot == SLOT_SEMA) begin
          sum = {1'b0, sh_sema[ch]} + {1'b0, wsh[7:0]};
          sh_sema[ch] = sum[8] ? 8'hFF : sum[7:0];
          if (wsh[7:0] != 8'h00 && !sh_ctrl[CTRL_SOFT_RESET_BIT] &&
              !sh_ctrl[CTRL_CLOCK_GATE_BIT] && sh_sema[ch] != 8'h00 &&
              sh_ndesc[ch] != 32'h0) begin
            o.start_valid = 1'b1;
            o.start_channel = 3'(ch);
          end
        end
      end
      CMD_DONE: begin
        if (r.done_flags[1] && sh_sema[r.channel] != 8'h00)
          sh_sema[r.channel] = sh_sema[r.channel] - 8'd1;
        if (r.done_flags[0]) sh_intr[r.channel] = 1'b1;
        if (r.done_flags[2] && sh_ndesc[r.channel] != 32'h0) begin
          o.start_valid = 1'b1;
          o.start_channel = r.channel;
        end
      end
      CMD_ERROR: begin
        sh_intr[16 + r.channel] = 1'b1;
      end
      default: ;
    endcase
    for (int i = 0; i < CHANNELS; i++)
      o.irq_lines[i] = (sh_intr[i] & sh_intr[8 + i]) | sh_intr[16 + i];
    return o;
  endfunction

  function automatic dir_row_t make_row(input logic [1:0] cmd, input logic [12:0] offset,
                                        input logic [2:0] size, input logic [31:0] wdata,
                                        input logic [2:0] ch, input logic [2:0] flags,
                                        input bit typed = 1'b0,
                                        input logic [31:0] rdata = 32'h0,
                                        input logic [7:0] irq = 8'h00);
    dir_row_t d;
    d.req = '{cmd: cmd, offset: offset, access_size: size, wdata: wdata,
              channel: ch, done_flags: flags};
    d.typed = typed;
    d.want = '{rdata: rdata, irq_lines: irq, start_valid: 1'b0, start_channel: 3'd0};
    return d;
  endfunction

  function automatic req_t random_access();
    req_t       r;
    int         pick;
    logic [8:0] unit;
    logic [1:0] lane;
    r.cmd = CMD_READ;
    r.access_size = 3'($urandom_range(1, 4));
    r.wdata = $urandom;
    r.channel = 3'($urandom_range(0, 7));
    r.done_flags = 3'($urandom_range(0, 7));
    lane = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
    case ($urandom_range(0, 7))
      0: unit = REG_CTRL;
      1: unit = REG_INTR;
      2: unit = REG_DSEL;
      3: unit = REG_VER_ID;
      4, 5: unit = chan_unit($urandom_range(0, 7),
                             $urandom_range(0, 1) ? SLOT_NEXT_DESC : SLOT_SEMA);
      default: unit = chan_unit($urandom_range(0, 7), $urandom_range(0, 6));
    endcase
    r.offset = reg_offset(unit, 2'($urandom_range(0, 3)), lane);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      r.offset = 13'($urandom_range(0, 8191));
    end else if (pick < 35) begin
      r.cmd = CMD_READ;
    end else if (pick < 65) begin
      r.cmd = CMD_WRITE;
      if ($urandom_range(0, 1)) r.wdata = 32'($urandom_range(0, 3));
      // keep the channels running most of the time
      if (unit == REG_CTRL && $urandom_range(0, 2) != 0) begin
        r.offset = reg_offset(REG_CTRL, ALIAS_WR, 2'd0);
        r.access_size = 3'd4;
        r.wdata[CTRL_SOFT_RESET_BIT] = 1'b0;
      end
    end else if (pick < 92) begin
      r.cmd = CMD_DONE;
    end else begin
      r.cmd = CMD_ERROR;
    end
    return r;
  endfunction

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 40) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic issue_access(input req_t r, input bit typed, input rsp_t typed_rsp);
    int   gap;
    rsp_t pred;
    gap = draw_gap(req_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk); while (!req_if.ready);
    pred = regfile_respond(r);
    pending_rsp_q.push_back(typed ? typed_rsp : pred);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_variant(input logic v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sh_ext = v;
  endtask

  // response side
  initial begin
    int   gap;
    rsp_t got, want;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(rsp_burst);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      got = rsp_if.data;
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response word, rdata", got.rdata, 32'h0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (got.rdata !== want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
        if (got.irq_lines !== want.irq_lines)
          report_mismatch("irq_lines", 32'(got.irq_lines), 32'(want.irq_lines));
        if (got.start_valid !== want.start_valid)
          report_mismatch("start_valid", 32'(got.start_valid), 32'(want.start_valid));
        if (got.start_channel !== want.start_channel)
          report_mismatch("start_channel", 32'(got.start_channel), 32'(want.start_channel));
      end
    end
  end

  // request side
  initial begin
    rsp_t none;
    none = '0;
    mismatches = 0;
    req_burst = 1'b0;
    rsp_burst = 1'b0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= 1'b0;
    sh_ext = 1'b0;
    sh_ctrl = CTRL_RESET;
    sh_intr = '0;
    sh_dsel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sh_ndesc[i] = '0;
      sh_sema[i] = '0;
    end

    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_CTRL, ALIAS_WR, 2'd0), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1, CTRL_RESET));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_VER_ID, ALIAS_WR, 2'd0), 3'd4,
                                     32'hFFFF_FFFF, 3'd7, 3'd7, 1'b1, VERSION_VALUE));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_VER_ID, ALIAS_WR, 2'd2), 3'd2,
                                     32'h0, 3'd0, 3'd0, 1'b1, 32'h0000_0101));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_VER_ID, ALIAS_WR, 2'd3), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1, 32'h0000_0001));
    // unmapped, top of the window
    directed_rows.push_back(make_row(CMD_READ, reg_offset(9'h1FF, ALIAS_TOG, 2'd3), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1, 32'h0));
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(REG_CTRL, ALIAS_WR, 2'd0), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_CTRL, ALIAS_WR, 2'd0), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1, 32'h0));
    // device select is read-only in the base variant
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(REG_DSEL, ALIAS_WR, 2'd0), 3'd4,
                                     32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(REG_DSEL, ALIAS_WR, 2'd0), 3'd4,
                                     32'h0, 3'd0, 3'd0, 1'b1, 32'h0));
    directed_rows.push_back(make_row(CMD_WRITE,
                                     reg_offset(chan_unit(0, SLOT_CUR_ADDR), ALIAS_WR, 2'd0),
                                     3'd4, 32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1));
    directed_rows.push_back(make_row(CMD_READ,
                                     reg_offset(chan_unit(0, SLOT_CUR_ADDR), ALIAS_WR, 2'd0),
                                     3'd4, 32'h0, 3'd0, 3'd0, 1'b1, 32'h0));
    directed_rows.push_back(make_row(CMD_WRITE,
                                     reg_offset(chan_unit(0, SLOT_NEXT_DESC), ALIAS_WR, 2'd0),
                                     3'd4, 32'h0000_1000, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(chan_unit(0, SLOT_SEMA), ALIAS_WR,
                                     2'd0), 3'd4, 32'h1, 3'd0, 3'd0));
    // saturating count
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(chan_unit(0, SLOT_SEMA), ALIAS_WR,
                                     2'd0), 3'd1, 32'hFF, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(chan_unit(0, SLOT_SEMA), ALIAS_WR,
                                     2'd0), 3'd4, 32'h0, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_READ, reg_offset(chan_unit(0, SLOT_DEBUG1), ALIAS_WR,
                                     2'd0), 3'd4, 32'h0, 3'd0, 3'd0));
    // increment only from the low lane
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(chan_unit(0, SLOT_SEMA), ALIAS_WR,
                                     2'd1), 3'd1, 32'h5, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_DONE, 13'h0, 3'd1, 32'h0, 3'd0, 3'd7));
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(REG_INTR, ALIAS_SET, 2'd0), 3'd4,
                                     32'h0000_FF00, 3'd0, 3'd0));
    // chained completion with a null descriptor, decrement of an empty count
    directed_rows.push_back(make_row(CMD_DONE, 13'h0, 3'd1, 32'h0, 3'd7, 3'd4));
    directed_rows.push_back(make_row(CMD_DONE, 13'h0, 3'd1, 32'h0, 3'd3, 3'd3));
    directed_rows.push_back(make_row(CMD_ERROR, 13'h0, 3'd1, 32'h0, 3'd7, 3'd0));
    directed_rows.push_back(make_row(CMD_WRITE,
                                     reg_offset(chan_unit(1, SLOT_NEXT_DESC), ALIAS_SET, 2'd0),
                                     3'd4, 32'hFFFF_FFFF, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_WRITE,
                                     reg_offset(chan_unit(1, SLOT_NEXT_DESC), ALIAS_CLR, 2'd2),
                                     3'd1, 32'hFF, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_READ,
                                     reg_offset(chan_unit(1, SLOT_NEXT_DESC), ALIAS_WR, 2'd0),
                                     3'd4, 32'h0, 3'd0, 3'd0));
    // soft reset back on: increments must not start a channel
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(REG_CTRL, ALIAS_TOG, 2'd0), 3'd4,
                                     32'h8000_0000, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(chan_unit(7, SLOT_SEMA), ALIAS_WR,
                                     2'd0), 3'd4, 32'h5, 3'd0, 3'd0));
    directed_rows.push_back(make_row(CMD_WRITE, reg_offset(REG_INTR, ALIAS_CLR, 2'd0), 3'd4,
                                     32'h00FF_FFFF, 3'd0, 3'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_access(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_variant(phase % 2 == 0);
      for (int n = 0; n < 360; n++) issue_access(random_access(), 1'b0, none);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
